// ===== hw/rtl/lat_pkg.sv =====
// Shared constants and types for the Langton's ant grid stepper.
`timescale 1ns / 1ps

package lat_pkg;

  // Grid geometry. Both sides are powers of two, so moves wrap by plain overflow.
  localparam int X_W        = 8;
  localparam int Y_W        = 7;
  localparam int ADDR_W     = X_W + Y_W;
  localparam int GRID_DEPTH = 1 << ADDR_W;
  localparam int CELL_W     = 2;

  // Cell codes.
  localparam logic [CELL_W-1:0] CELL_CLEAR     = 2'd0;
  localparam logic [CELL_W-1:0] CELL_SET       = 2'd1;
  localparam logic [CELL_W-1:0] CELL_UNVISITED = 2'd2;

  // Command codes.
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Headings.
  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  // Ant position after reset.
  localparam logic [X_W-1:0] START_X = X_W'(50);
  localparam logic [Y_W-1:0] START_Y = Y_W'(50);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;  // write one unvisited cell of the clearing pass
    logic issue;   // item accepted: launch the cell read, latch the command
    logic exec;    // read data is back: for a step update cell and ant; update the result
  } lat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at the last cell
  } lat_sts_t;

endpackage

// ===== hw/rtl/langton_ant_grid_step_top.sv =====
// Top level of the Langton's ant grid stepper: controller plus datapath.
`timescale 1ns / 1ps

// Langton's ant on a 256 by 128 toroidal grid whose cells are unvisited, clear
// or set. A command transfer happens at a rising edge where start is high and
// busy is low; in_cmd selects a step of the ant or a read of the cell at
// in_read_x, in_read_y. Every command gives exactly one result transfer:
// out_valid is high for one cycle with the ant's position and heading after the
// command, and out_cell_set, which for a step is the value written to the cell
// the ant just left and for a read tells whether that cell is set (unvisited
// cells read as not set). The receiver cannot stall, so it must take the
// result in the cycle it appears. The cell is read from the grid memory,
// whose read is registered; in the next cycle a step writes the cell back
// and moves the ant, and the result shows in the cycle after that. Busy stays
// high until the command has executed, so a new command is accepted only then.
// After reset the block holds busy high while it writes all 32768 cells to
// unvisited, one cell per cycle; the ant then starts at column 50, row 50,
// facing west.

module langton_ant_grid_step_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_cmd,
  input  logic [lat_pkg::X_W-1:0] in_read_x,
  input  logic [lat_pkg::Y_W-1:0] in_read_y,
  output logic                    out_valid,
  output logic [lat_pkg::X_W-1:0] out_ant_x,
  output logic [lat_pkg::Y_W-1:0] out_ant_y,
  output logic [1:0]              out_ant_heading,
  output logic                    out_cell_set
);
  import lat_pkg::*;

  lat_cmd_t cmd;
  lat_sts_t sts;

  // The controller sequences the clearing pass and each command.
  lat_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  // The datapath owns the grid memory, the ant and the result registers.
  lat_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_read_x      (in_read_x),
    .in_read_y      (in_read_y),
    .out_valid      (out_valid),
    .out_ant_x      (out_ant_x),
    .out_ant_y      (out_ant_y),
    .out_ant_heading(out_ant_heading),
    .out_cell_set   (out_cell_set)
  );

endmodule

// ===== hw/rtl/lat_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lat_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lat_ctrl.sv =====
// Controller state machine: clearing pass, idle, and the execute cycle of an item.
`timescale 1ns / 1ps

module lat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output lat_pkg::lat_cmd_t cmd,
  input  lat_pkg::lat_sts_t sts
);
  import lat_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.issue = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hw/rtl/lat_dp.sv =====
// Datapath: grid memory, clear counter, ant registers and result registers.
`timescale 1ns / 1ps

module lat_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lat_pkg::lat_cmd_t         cmd,
  output lat_pkg::lat_sts_t         sts,
  input  logic                      in_cmd,
  input  logic [lat_pkg::X_W-1:0]   in_read_x,
  input  logic [lat_pkg::Y_W-1:0]   in_read_y,
  output logic                      out_valid,
  output logic [lat_pkg::X_W-1:0]   out_ant_x,
  output logic [lat_pkg::Y_W-1:0]   out_ant_y,
  output logic [1:0]                out_ant_heading,
  output logic                      out_cell_set
);
  import lat_pkg::*;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [X_W-1:0]    pos_x_r, pos_x_nxt;
  logic [Y_W-1:0]    pos_y_r, pos_y_nxt;
  logic [1:0]        head_r, head_nxt;
  logic              cmd_r;
  logic              valid_r;
  logic [X_W-1:0]    res_x_r;
  logic [Y_W-1:0]    res_y_r;
  logic [1:0]        res_head_r;
  logic              res_flag_r;
  logic              flag_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] step_cell;

  // A step reads the ant's own cell; a read command reads the requested one.
  assign rd_addr = (in_cmd == CMD_READ) ? {in_read_y, in_read_x} : {pos_y_r, pos_x_r};

  lat_ram #(
    .WIDTH(CELL_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.issue),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    head_nxt  = head_r;
    step_cell = CELL_CLEAR;
    flag_nxt  = 1'b0;
    if (cmd_r == CMD_STEP) begin
      // Unvisited cells turn left just as set cells do.
      if (rd_data == CELL_CLEAR) begin
        step_cell = CELL_SET;
        head_nxt  = head_r + 2'd1;
        flag_nxt  = 1'b1;
      end else begin
        step_cell = CELL_CLEAR;
        head_nxt  = head_r - 2'd1;
        flag_nxt  = 1'b0;
      end
      unique case (head_nxt)
        HEAD_NORTH: pos_y_nxt = pos_y_r - Y_W'(1);
        HEAD_EAST:  pos_x_nxt = pos_x_r + X_W'(1);
        HEAD_SOUTH: pos_y_nxt = pos_y_r + Y_W'(1);
        HEAD_WEST:  pos_x_nxt = pos_x_r - X_W'(1);
        default:    pos_x_nxt = pos_x_r;
      endcase
    end else begin
      flag_nxt = (rd_data == CELL_SET);
    end
  end

  // The clearing pass and the step write never overlap.
  always_comb begin
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = CELL_UNVISITED;
    end else begin
      wr_en   = cmd.exec && (cmd_r == CMD_STEP);
      wr_addr = {pos_y_r, pos_x_r};
      wr_data = step_cell;
    end
  end

  assign sts.clr_last = (clr_cnt_r == {ADDR_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pos_x_r   <= START_X;
      pos_y_r   <= START_Y;
      head_r    <= HEAD_WEST;
      valid_r   <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.exec) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        head_r  <= head_nxt;
      end
      valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cmd_r <= in_cmd;
    end
    if (cmd.exec) begin
      res_x_r    <= pos_x_nxt;
      res_y_r    <= pos_y_nxt;
      res_head_r <= head_nxt;
      res_flag_r <= flag_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_ant_x       = res_x_r;
  assign out_ant_y       = res_y_r;
  assign out_ant_heading = res_head_r;
  assign out_cell_set    = res_flag_r;

endmodule
